>>> rtl/itcs_pkg.sv
`timescale 1ns / 1ps

package itcs_pkg;

   localparam logic [15:0] WORD_MAX     = 16'hffff;
   localparam logic [15:0] PROTO_TCP    = 16'd6;
   localparam logic [15:0] IP_CSUM_POS  = 16'd10;
   localparam logic [15:0] ADDR_FIRST   = 16'd12;
   localparam logic [15:0] MIN_HEADER   = 16'd20;
   localparam logic [15:0] TCP_CSUM_POS = 16'd16;
   localparam logic [15:0] MIN_SEGMENT  = 16'd18;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_HDR   = 2'd1;
   localparam logic [1:0] STATUS_SHORT_SEG = 2'd2;

   // Packet totals frozen at the last byte
   typedef struct packed {
      logic [15:0] header_sum;
      logic [15:0] segment_sum;
      logic [15:0] pad_word;
      logic [15:0] segment_count;
      logic [1:0]  status;
   } snap_type;

   typedef struct packed {
      logic [15:0] ip_header_checksum;
      logic [15:0] tcp_segment_checksum;
      logic [15:0] segment_length;
      logic [1:0]  status;
   } result_type;

   // End-around carry fold of a sum of up to four 16-bit words
   function automatic logic [15:0] fold18(input logic [17:0] s);
      logic [16:0] f;
      f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
      return f[15:0] + {15'd0, f[16]};
   endfunction

endpackage

>>> rtl/itcs_req_if.sv
`timescale 1ns / 1ps

interface itcs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

>>> rtl/itcs_rsp_if.sv
`timescale 1ns / 1ps

interface itcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] ip_header_checksum;
   logic [15:0] tcp_segment_checksum;
   logic [15:0] segment_length;
   logic [1:0]  status;

   modport source (output valid, output ip_header_checksum, output tcp_segment_checksum,
                   output segment_length, output status, input ready);
   modport sink (input valid, input ip_header_checksum, input tcp_segment_checksum,
                 input segment_length, input status, output ready);
endinterface

>>> rtl/itcs_accum.sv
`timescale 1ns / 1ps

module itcs_accum (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_go,
   input  logic [7:0]           byte_value,
   input  logic                 last_byte,
   output itcs_pkg::snap_type   snap
);

   logic [15:0] pos_ff, pos_in;
   logic [5:0]  hdr_len_ff, hdr_len_in;
   logic [15:0] hdr_sum_ff, hdr_sum_in;
   logic [15:0] seg_sum_ff, seg_sum_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] count_ff, count_in;

   logic        active;
   logic [5:0]  hdr_len;
   logic [15:0] shifted;
   logic        in_hdr;
   logic [15:0] off;
   logic [7:0]  seg_byte;
   logic [15:0] addr_term;
   logic [15:0] word_term;
   logic [15:0] hdr_sum_n, seg_sum_n, count_n, pos_n;
   logic [7:0]  held_n;

   always_comb begin
      active   = pos_ff != itcs_pkg::WORD_MAX;
      hdr_len  = (pos_ff == 16'd0) ? {byte_value[3:0], 2'b00} : hdr_len_ff;
      shifted  = pos_ff[0] ? {8'd0, byte_value} : {byte_value, 8'd0};
      in_hdr   = pos_ff < {10'd0, hdr_len};
      off      = pos_ff - {10'd0, hdr_len};
      seg_byte = (off == itcs_pkg::TCP_CSUM_POS || off == itcs_pkg::TCP_CSUM_POS + 16'd1)
                 ? 8'd0 : byte_value;

      // address bytes feed the pseudo-header wherever they fall
      addr_term = (pos_ff >= itcs_pkg::ADDR_FIRST && pos_ff < itcs_pkg::MIN_HEADER)
                  ? shifted : 16'd0;
      word_term = (!in_hdr && off[0]) ? {held_ff, seg_byte} : 16'd0;

      hdr_sum_n = hdr_sum_ff;
      if (in_hdr && pos_ff != itcs_pkg::IP_CSUM_POS
          && pos_ff != itcs_pkg::IP_CSUM_POS + 16'd1) begin
         hdr_sum_n = itcs_pkg::fold18({2'd0, hdr_sum_ff} + {2'd0, shifted});
      end
      seg_sum_n = itcs_pkg::fold18({2'd0, seg_sum_ff} + {2'd0, addr_term}
                                   + {2'd0, word_term});
      held_n    = (!in_hdr && !off[0]) ? seg_byte : held_ff;
      count_n   = count_ff;
      if (!in_hdr && count_ff != itcs_pkg::WORD_MAX) begin
         count_n = count_ff + 16'd1;
      end
      pos_n = pos_ff + 16'd1;

      // oversize packet: bytes past the position limit change nothing
      if (!active) begin
         hdr_len   = hdr_len_ff;
         hdr_sum_n = hdr_sum_ff;
         seg_sum_n = seg_sum_ff;
         held_n    = held_ff;
         count_n   = count_ff;
         pos_n     = pos_ff;
      end
   end

   always_comb begin
      snap.header_sum    = hdr_sum_n;
      snap.segment_sum   = seg_sum_n;
      snap.pad_word      = count_n[0] ? {held_n, 8'd0} : 16'd0;
      snap.segment_count = count_n;
      if ({10'd0, hdr_len} < itcs_pkg::MIN_HEADER || pos_n < {10'd0, hdr_len}) begin
         snap.status = itcs_pkg::STATUS_BAD_HDR;
      end else if (count_n < itcs_pkg::MIN_SEGMENT) begin
         snap.status = itcs_pkg::STATUS_SHORT_SEG;
      end else begin
         snap.status = itcs_pkg::STATUS_OK;
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      hdr_len_in = hdr_len_ff;
      hdr_sum_in = hdr_sum_ff;
      seg_sum_in = seg_sum_ff;
      held_in    = held_ff;
      count_in   = count_ff;
      if (item_go) begin
         if (last_byte) begin
            pos_in     = 16'd0;
            hdr_len_in = 6'd0;
            hdr_sum_in = 16'd0;
            seg_sum_in = 16'd0;
            held_in    = 8'd0;
            count_in   = 16'd0;
         end else begin
            pos_in     = pos_n;
            hdr_len_in = hdr_len;
            hdr_sum_in = hdr_sum_n;
            seg_sum_in = seg_sum_n;
            held_in    = held_n;
            count_in   = count_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 16'd0;
         hdr_len_ff <= 6'd0;
         hdr_sum_ff <= 16'd0;
         seg_sum_ff <= 16'd0;
         held_ff    <= 8'd0;
         count_ff   <= 16'd0;
      end else begin
         pos_ff     <= pos_in;
         hdr_len_ff <= hdr_len_in;
         hdr_sum_ff <= hdr_sum_in;
         seg_sum_ff <= seg_sum_in;
         held_ff    <= held_in;
         count_ff   <= count_in;
      end
   end

endmodule

>>> rtl/itcs_finish.sv
`timescale 1ns / 1ps

module itcs_finish (
   input  itcs_pkg::snap_type   snap,
   output itcs_pkg::result_type result
);

   logic [17:0] tcp_total;

   always_comb begin
      // pad, protocol and length close the pseudo-header sum
      tcp_total = {2'd0, snap.segment_sum} + {2'd0, snap.pad_word}
                + {2'd0, itcs_pkg::PROTO_TCP} + {2'd0, snap.segment_count};
      result.ip_header_checksum   = ~snap.header_sum;
      result.tcp_segment_checksum = ~itcs_pkg::fold18(tcp_total);
      result.segment_length       = snap.segment_count;
      result.status               = snap.status;
   end

endmodule

>>> rtl/ipv4_tcp_checksum_stream_unit.sv
`timescale 1ns / 1ps

// IPv4 header and TCP segment checksum unit, one packet byte per item.
// Throughput: one byte item per cycle while no last byte waits on the output;
// one result item per packet, through the totals and result registers.
// Reset (synchronous, active high) empties all stages and clears packet state.

module ipv4_tcp_checksum_stream_unit (
   input  logic       clock,
   input  logic       reset,
   itcs_req_if.sink   req_chan,
   itcs_rsp_if.source rsp_chan
);

   // Stage 1: byte register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   // Stage 2: packet totals frozen at the last byte
   logic                 snap_valid_ff, snap_valid_in;
   itcs_pkg::snap_type   snap_ff, snap_calc;

   // Stage 3: result register
   logic                 rsp_valid_ff, rsp_valid_in;
   itcs_pkg::result_type rsp_ff, rsp_calc;

   logic out_rdy;
   logic snap_rdy;
   logic in_go;
   logic req_take;

   // Each stage moves on its own; bytes that end no packet never wait on the
   // output, so the byte stream keeps flowing while a result sits unclaimed.
   always_comb begin
      out_rdy  = !rsp_valid_ff || rsp_chan.ready;
      snap_rdy = !snap_valid_ff || out_rdy;
      in_go    = in_valid_ff && (!last_ff || snap_rdy);
      req_take = req_chan.valid && (!in_valid_ff || in_go);
   end

   assign req_chan.ready = !in_valid_ff || in_go;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_go) begin
         in_valid_in = 1'b0;
      end

      snap_valid_in = snap_valid_ff;
      if (in_go && last_ff) begin
         snap_valid_in = 1'b1;
      end else if (out_rdy) begin
         snap_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (snap_valid_ff && out_rdy) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Running sums, byte position and header length
   itcs_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .item_go    (in_go),
      .byte_value (byte_ff),
      .last_byte  (last_ff),
      .snap       (snap_calc)
   );

   // Final fold and complement
   itcs_finish u_finish (
      .snap   (snap_ff),
      .result (rsp_calc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         byte_ff <= req_chan.byte_value;
         last_ff <= req_chan.last_byte;
      end
      if (in_go && last_ff) begin
         snap_ff <= snap_calc;
      end
      if (snap_valid_ff && out_rdy) begin
         rsp_ff <= rsp_calc;
      end
   end

   assign rsp_chan.valid                = rsp_valid_ff;
   assign rsp_chan.ip_header_checksum   = rsp_ff.ip_header_checksum;
   assign rsp_chan.tcp_segment_checksum = rsp_ff.tcp_segment_checksum;
   assign rsp_chan.segment_length       = rsp_ff.segment_length;
   assign rsp_chan.status               = rsp_ff.status;

endmodule

>>> rtl/itcs_checker.sv
`timescale 1ns / 1ps

module itcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_ip,
   input logic [15:0] rsp_tcp,
   input logic [15:0] rsp_len,
   input logic [1:0]  rsp_status
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ip) && $stable(rsp_tcp)
                                  && $stable(rsp_len) && $stable(rsp_status))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == itcs_pkg::STATUS_OK |-> rsp_len >= itcs_pkg::MIN_SEGMENT)
      else $error("ok status on short segment");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == itcs_pkg::STATUS_SHORT_SEG
      |-> rsp_len < itcs_pkg::MIN_SEGMENT)
      else $error("short segment status on long segment");

endmodule

bind ipv4_tcp_checksum_stream_unit itcs_checker u_itcs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_ip     (rsp_chan.ip_header_checksum),
   .rsp_tcp    (rsp_chan.tcp_segment_checksum),
   .rsp_len    (rsp_chan.segment_length),
   .rsp_status (rsp_chan.status)
);

>>> tb/ipv4_tcp_checksum_stream_unit_tb.sv
`timescale 1ns / 1ps

module ipv4_tcp_checksum_stream_unit_tb;

   // Watchdog: cycles with no item accepted on either side
   localparam int IDLE_LIMIT = 3000;
   // Receiver hold-off used once to back the block up
   localparam int LONG_HOLD = 300;
   localparam int RANDOM_BYTES = 800;
   localparam int RANDOM_PACKETS = 12;

   // Fill patterns for packet bodies
   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   // Scoreboard: tracks the packet sums as bytes are taken, and holds
   // the checksum results still owed by the block, oldest first.
   class scoreboard_type;
      logic [15:0]          pos_count;
      logic [5:0]           hdr_len;
      logic [15:0]          hdr_acc;
      logic [15:0]          seg_acc;
      logic [7:0]           odd_hi;
      logic [15:0]          seg_len;
      itcs_pkg::result_type owed_sums[$];
      int                   errors;
      int                   checked;
      int                   status_hits[4];

      function new();
         errors = 0;
         checked = 0;
         foreach (status_hits[i]) status_hits[i] = 0;
         clear_packet();
      endfunction

      function void clear_packet();
         pos_count = '0;
         hdr_len   = '0;
         hdr_acc   = '0;
         seg_acc   = '0;
         odd_hi    = '0;
         seg_len   = '0;
      endfunction

      // End-around carry add of two 16-bit words
      function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
         logic [16:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[15:0] + {15'd0, s[16]};
      endfunction

      function int pending();
         return owed_sums.size();
      endfunction

      // Note one accepted byte item; the last byte owes a result
      function void take_byte(logic [7:0] b, logic last);
         logic [15:0]          shifted;
         logic [15:0]          off;
         logic [7:0]           v;
         logic [15:0]          seg;
         itcs_pkg::result_type r;
         if (pos_count != itcs_pkg::WORD_MAX) begin
            shifted = pos_count[0] ? {8'h00, b} : {b, 8'h00};
            if (pos_count == 16'd0) hdr_len = {b[3:0], 2'b00};
            // Addresses enter the pseudo-header wherever they fall
            if (pos_count >= itcs_pkg::ADDR_FIRST && pos_count < itcs_pkg::MIN_HEADER)
               seg_acc = ones_add(seg_acc, shifted);
            if (pos_count < {10'd0, hdr_len}) begin
               if (pos_count != itcs_pkg::IP_CSUM_POS
                   && pos_count != itcs_pkg::IP_CSUM_POS + 16'd1)
                  hdr_acc = ones_add(hdr_acc, shifted);
            end else begin
               off = pos_count - {10'd0, hdr_len};
               v = (off == itcs_pkg::TCP_CSUM_POS || off == itcs_pkg::TCP_CSUM_POS + 16'd1)
                   ? 8'h00 : b;
               if (!off[0]) odd_hi = v;
               else seg_acc = ones_add(seg_acc, {odd_hi, v});
               if (seg_len != itcs_pkg::WORD_MAX) seg_len = seg_len + 16'd1;
            end
            pos_count = pos_count + 16'd1;
         end
         if (last) begin
            seg = seg_acc;
            if (seg_len[0]) seg = ones_add(seg, {odd_hi, 8'h00});
            seg = ones_add(seg, itcs_pkg::PROTO_TCP);
            seg = ones_add(seg, seg_len);
            r.ip_header_checksum   = ~hdr_acc;
            r.tcp_segment_checksum = ~seg;
            r.segment_length       = seg_len;
            if ({10'd0, hdr_len} < itcs_pkg::MIN_HEADER || pos_count < {10'd0, hdr_len})
               r.status = itcs_pkg::STATUS_BAD_HDR;
            else if (seg_len < itcs_pkg::MIN_SEGMENT)
               r.status = itcs_pkg::STATUS_SHORT_SEG;
            else
               r.status = itcs_pkg::STATUS_OK;
            owed_sums = {owed_sums, r};
            clear_packet();
         end
      endfunction

      function void check_result(itcs_pkg::result_type got);
         itcs_pkg::result_type want;
         if (owed_sums.size() == 0) begin
            $error("result item with none expected: %h", got);
            errors++;
            return;
         end
         want = owed_sums.pop_front();
         checked++;
         status_hits[want.status]++;
         if (got.ip_header_checksum !== want.ip_header_checksum) begin
            $error("ip_header_checksum: expected %h, got %h",
                   want.ip_header_checksum, got.ip_header_checksum);
            errors++;
         end
         if (got.tcp_segment_checksum !== want.tcp_segment_checksum) begin
            $error("tcp_segment_checksum: expected %h, got %h",
                   want.tcp_segment_checksum, got.tcp_segment_checksum);
            errors++;
         end
         if (got.segment_length !== want.segment_length) begin
            $error("segment_length: expected %0d, got %0d",
                   want.segment_length, got.segment_length);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   itcs_req_if req_chan ();
   itcs_rsp_if rsp_chan ();

   ipv4_tcp_checksum_stream_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   scoreboard_type sb = new();

   logic [7:0] pkt_bytes[$];
   bit         quiet;          // no new random gaps on either side while set
   bit         hold_request;   // asks the receiver for its long hold-off
   int         hold_cnt;
   int         rsp_gap;
   int         idle_cycles;
   int         bytes_sent;
   int         packets_sent;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Builds a packet of total_len bytes; byte 0 carries the IHL.
   // A random version nibble marks noise rather than a well-formed header.
   task automatic build_packet(input int ihl, input int total_len, input fill_type fill,
                               input bit any_version);
      logic [7:0] b;
      pkt_bytes.delete();
      for (int i = 0; i < total_len; i++) begin
         case (fill)
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = 8'hff;
            default:   b = 8'($urandom_range(0, 255));
         endcase
         if (i == 0) begin
            b[3:0] = 4'(ihl);
            if (fill == FILL_ONES) b[7:4] = 4'hf;
            else if (!any_version) b[7:4] = 4'h4;
         end
         pkt_bytes = {pkt_bytes, b};
      end
   endtask

   // Offer one byte item at the falling edge, hold it until taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = quiet ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.byte_value <= b;
      req_chan.last_byte  <= last;
      do @(posedge clock); while (!req_chan.ready);
      sb.take_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_packet();
      foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
      packets_sent++;
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      hold_cnt = 0;
      rsp_gap = 0;
      forever begin
         @(negedge clock);
         if (hold_cnt == 0 && hold_request) begin
            hold_cnt = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!quiet && !reset) rsp_gap = pick_gap();
         end
      end
   end

   // Result monitor; the long hold-off starts once the random part is under way
   always @(posedge clock) begin
      itcs_pkg::result_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.ip_header_checksum   = rsp_chan.ip_header_checksum;
         got.tcp_segment_checksum = rsp_chan.tcp_segment_checksum;
         got.segment_length       = rsp_chan.segment_length;
         got.status               = rsp_chan.status;
         sb.check_result(got);
         if (sb.checked == 14) hold_request = 1'b1;
      end
   end

   // Watchdog on progress
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int r;
      int ihl;
      int seg;
      int rand_from;
      reset = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.byte_value = 8'h00;
      req_chan.last_byte  = 1'b0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      bytes_sent   = 0;
      packets_sent = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Corner packets
      build_packet(15, 1, FILL_ONES, 1'b0);   // single byte, header cut short
      send_packet();
      build_packet(0, 1, FILL_ZERO, 1'b1);    // single zero byte, all segment
      send_packet();
      build_packet(5, 38, FILL_ONES, 1'b0);   // minimum good segment, all ones
      send_packet();
      build_packet(5, 37, FILL_ONES, 1'b0);   // one byte short of minimum segment
      send_packet();
      build_packet(5, 20, FILL_ZERO, 1'b0);   // header only, empty segment
      send_packet();
      build_packet(15, 81, FILL_RANDOM, 1'b0); // largest header, odd segment
      send_packet();
      build_packet(4, 40, FILL_RANDOM, 1'b0); // header field under 20 bytes
      send_packet();
      build_packet(0, 30, FILL_RANDOM, 1'b1); // zero header, addresses in segment
      send_packet();
      build_packet(5, 12, FILL_RANDOM, 1'b0); // truncated inside the header
      send_packet();
      build_packet(6, 24, FILL_RANDOM, 1'b0); // header exactly complete
      send_packet();
      build_packet(1, 19, FILL_RANDOM, 1'b1); // tiny header, short odd segment
      send_packet();

      // Random part: mostly well-formed packets, the rest short or noise
      rand_from = bytes_sent;
      while (bytes_sent - rand_from < RANDOM_BYTES || packets_sent < 11 + RANDOM_PACKETS) begin
         quiet = ($urandom_range(0, 7) == 0);
         r = $urandom_range(0, 9);
         if (r < 6) begin
            ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(5, 7);
            seg = $urandom_range(18, 40);
            build_packet(ihl, ihl * 4 + seg, FILL_RANDOM, 1'b0);
         end else if (r < 8) begin
            ihl = $urandom_range(5, 6);
            build_packet(ihl, ihl * 4 + $urandom_range(0, 17), FILL_RANDOM, 1'b0);
         end else begin
            build_packet($urandom_range(0, 15), $urandom_range(1, 40), FILL_RANDOM, 1'b1);
         end
         send_packet();
      end
      quiet = 1'b0;
      @(negedge clock);
      req_chan.valid <= 1'b0;

      // Drain, then allow for the block's latency
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d packets in %0d byte items: corner packets, then random traffic.",
               packets_sent, bytes_sent);
      $display("Checked %0d results: %0d ok, %0d bad header, %0d short segment.",
               sb.checked, sb.status_hits[itcs_pkg::STATUS_OK],
               sb.status_hits[itcs_pkg::STATUS_BAD_HDR],
               sb.status_hits[itcs_pkg::STATUS_SHORT_SEG]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/itcs_pkg.sv
rtl/itcs_req_if.sv
rtl/itcs_rsp_if.sv
rtl/itcs_accum.sv
rtl/itcs_finish.sv
rtl/ipv4_tcp_checksum_stream_unit.sv
rtl/itcs_checker.sv
tb/ipv4_tcp_checksum_stream_unit_tb.sv
